>>> rtl/core/tknh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tknh_pkg;

  // fixed field widths
  localparam int unsigned DIST_W = 32;
  localparam int unsigned IDX_W  = 24;
  localparam int unsigned K_W    = 6;

  // reset value of the k register
  localparam logic [K_W-1:0] K_RESET = K_W'(32);

  // request kinds
  localparam logic KIND_CAND   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // one heap entry
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/tknh_heap_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tknh_heap_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire tknh_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr_a,
  input  wire logic [AW-1:0]   raddr_b,
  output tknh_pkg::entry_t     rdata_a,
  output tknh_pkg::entry_t     rdata_b
);
  import tknh_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rdata_a_r;
  entry_t rdata_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> rtl/core/tknh_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tknh_seq #(
  parameter int unsigned MAX_K = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned CW    = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [tknh_pkg::K_W-1:0]  k_in_use,
  // request side
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [tknh_pkg::DIST_W-1:0] in_distance,
  input  wire logic [tknh_pkg::IDX_W-1:0]  in_index,
  // result side
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [tknh_pkg::DIST_W-1:0]    out_distance_out,
  output logic [tknh_pkg::IDX_W-1:0]     out_index_out,
  output logic                           out_empty_res,
  output logic                           out_last,
  // heap memory
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output tknh_pkg::entry_t               mem_wdata,
  output logic [AW-1:0]                  mem_raddr_a,
  output logic [AW-1:0]                  mem_raddr_b,
  input  wire tknh_pkg::entry_t          mem_rdata_a,
  input  wire tknh_pkg::entry_t          mem_rdata_b
);
  import tknh_pkg::*;

  localparam int unsigned LW = AW + 2;
  localparam int unsigned KXW = (K_W > CW ? K_W : CW) + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_RD   = 3'd3;
  localparam logic [2:0] S_DN_CMP  = 3'd4;
  localparam logic [2:0] S_DR_EMIT = 3'd5;
  localparam logic [2:0] S_DR_LOAD = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          drain_r, drain_nxt;
  entry_t        cur_r, cur_nxt;
  entry_t        root_r, root_nxt;
  logic          out_valid_r, out_valid_nxt;
  entry_t        out_ent_r, out_ent_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_last_r, out_last_nxt;

  logic [KXW-1:0] k_eff;
  logic [KXW-1:0] fill_x;
  logic [LW-1:0]  pos_x, lc_x, rc_x, fill_l;
  logic [AW-1:0]  parent;
  logic           out_free;
  logic           right_pick;
  entry_t         child;
  logic [AW-1:0]  child_addr;
  logic [DIST_W-1:0] cmp_a, cmp_b;
  logic           cmp_gt;

  // k of zero counts as one, above MAX_K clamps
  always_comb begin
    if (k_in_use == '0) begin
      k_eff = KXW'(1);
    end else if (KXW'(k_in_use) > KXW'(MAX_K)) begin
      k_eff = KXW'(MAX_K);
    end else begin
      k_eff = KXW'(k_in_use);
    end
  end

  // heap index arithmetic, 0-based slots
  assign fill_x = KXW'(fill_r);
  assign fill_l = LW'(fill_r);
  assign pos_x  = LW'(pos_r);
  assign lc_x   = (pos_x << 1) + LW'(1);
  assign rc_x   = lc_x + LW'(1);
  assign parent = AW'((pos_x - LW'(1)) >> 1);
  assign out_free = !out_valid_r || out_ready;

  // sift-down child pick: right only when strictly larger
  assign right_pick = (rc_x < fill_l) && (mem_rdata_b.distance > mem_rdata_a.distance);
  assign child      = right_pick ? mem_rdata_b : mem_rdata_a;
  assign child_addr = right_pick ? AW'(rc_x) : AW'(lc_x);

  // the one shared magnitude comparator
  always_comb begin
    cmp_a = cur_r.distance;
    cmp_b = root_r.distance;
    unique case (state_r)
      S_IDLE:   begin
        // root above the candidate means the candidate is kept
        cmp_a = root_r.distance;
        cmp_b = in_distance;
      end
      S_UP_CMP: cmp_b = mem_rdata_a.distance;
      S_DN_CMP: cmp_b = child.distance;
      default:  cmp_b = root_r.distance;
    endcase
  end
  assign cmp_gt = cmp_a > cmp_b;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    drain_nxt     = drain_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ent_nxt   = out_ent_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = cur_r;
    mem_raddr_a   = parent;
    mem_raddr_b   = AW'(rc_x);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_FINISH) begin
            state_nxt = S_DR_EMIT;
          end else if (fill_r == '0 || cmp_gt) begin
            cur_nxt   = '{distance: in_distance, idx: in_index};
            drain_nxt = 1'b0;
            if (fill_x < k_eff) begin
              pos_nxt   = AW'(fill_r);
              fill_nxt  = fill_r + CW'(1);
              state_nxt = S_UP_RD;
            end else begin
              pos_nxt   = '0;
              state_nxt = S_DN_RD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_DN_RD: begin
        mem_raddr_a = AW'(lc_x);
        if (lc_x >= fill_l) begin
          mem_we    = 1'b1;
          state_nxt = drain_r ? S_DR_EMIT : S_IDLE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          state_nxt = drain_r ? S_DR_EMIT : S_IDLE;
        end else begin
          mem_wdata = child;
          pos_nxt   = child_addr;
          state_nxt = S_DN_RD;
        end
      end

      S_DR_EMIT: begin
        mem_raddr_a = AW'(fill_r - CW'(1));
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fill_r == '0) begin
            out_ent_nxt   = '0;
            out_empty_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            out_ent_nxt   = root_r;
            out_empty_nxt = 1'b0;
            out_last_nxt  = (fill_r == CW'(1));
            fill_nxt      = fill_r - CW'(1);
            drain_nxt     = 1'b1;
            state_nxt     = S_DR_LOAD;
          end
        end
      end

      S_DR_LOAD: begin
        cur_nxt = mem_rdata_a;
        pos_nxt = '0;
        if (fill_r == '0) begin
          drain_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // root shadow follows every write to slot zero
  always_comb begin
    root_nxt = root_r;
    if (mem_we && mem_waddr == '0) begin
      root_nxt = mem_wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    root_r      <= root_nxt;
    out_ent_r   <= out_ent_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_distance_out = out_ent_r.distance;
  assign out_index_out    = out_ent_r.idx;
  assign out_empty_res    = out_empty_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

>>> rtl/core/top_k_nearest_max_heap_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | kind, distance, index
// out_    | output    | out_valid/out_ready | distance_out, index_out, empty_res, last
// cfg_    | input     | cfg_we (no wait)    | cfg_wdata = k_in_use
//
// Candidate: accepted in idle (all a rejected one needs), then each heap level
// of sift-up or sift-down takes a read state and a compare state on the shared
// comparator, and a final write closes it.
// Finish: each popped result comes from the root shadow, then the last slot is
// loaded and sifted down from the root; an empty heap gives one empty result.
// rst_n is synchronous; it empties the heap and sets k to 32.
// A stalled out_ready holds the drain; in_ready is low while a request works.

module top_k_nearest_max_heap_unit #(
  parameter int unsigned MAX_K = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic [tknh_pkg::DIST_W-1:0]   in_distance,
  input  wire logic [tknh_pkg::IDX_W-1:0]    in_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tknh_pkg::DIST_W-1:0]        out_distance_out,
  output logic [tknh_pkg::IDX_W-1:0]         out_index_out,
  output logic                               out_empty_res,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [tknh_pkg::K_W-1:0]      cfg_wdata
);
  import tknh_pkg::*;

  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);

  logic [K_W-1:0] k_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr_a, mem_raddr_b;
  entry_t         mem_wdata, mem_rdata_a, mem_rdata_b;

  // k register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  tknh_seq #(
    .MAX_K (MAX_K),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .k_in_use         (k_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_distance      (in_distance),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_distance_out (out_distance_out),
    .out_index_out    (out_index_out),
    .out_empty_res    (out_empty_res),
    .out_last         (out_last),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr_a      (mem_raddr_a),
    .mem_raddr_b      (mem_raddr_b),
    .mem_rdata_a      (mem_rdata_a),
    .mem_rdata_b      (mem_rdata_b)
  );

  tknh_heap_mem #(
    .DEPTH (MAX_K),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule

`default_nettype wire

>>> rtl/core/tknh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tknh_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_kind,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tknh_pkg::DIST_W-1:0] out_distance_out,
  input wire logic [tknh_pkg::IDX_W-1:0]  out_index_out,
  input wire logic                        out_empty_res,
  input wire logic                        out_last
);
  import tknh_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_out)
      && $stable(out_index_out) && $stable(out_last))
    else $error("result changed while stalled");

  // the empty result is a single, final, zero result
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_distance_out == '0
      && out_index_out == '0)
    else $error("malformed empty result");

  // no new request while a drain is still under way
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken in the middle of a drain");

  // a candidate request never produces a result
  a_cand_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_CAND && !out_valid |=> !out_valid)
    else $error("result after a candidate");

endmodule

bind top_k_nearest_max_heap_unit tknh_checker u_tknh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_distance_out (out_distance_out),
  .out_index_out    (out_index_out),
  .out_empty_res    (out_empty_res),
  .out_last         (out_last)
);

`default_nettype wire
